// File: rtl/ba_pkg.sv
`timescale 1ns / 1ps

package ba_pkg;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FAIL      = 2'd1,
    ST_IGNORED   = 2'd2,
    ST_RESERVED  = 2'd3
  } status_e;

  localparam logic CFG_BASE_ADDRESS = 1'b0;
  localparam logic CFG_AREA_BYTES   = 1'b1;

  localparam logic [14:0] AREA_BYTES_RESET = 15'd16384;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] request_bytes;
    logic [31:0] free_address;
  } in_word_t;

  typedef struct packed {
    logic [31:0] address;
    logic [1:0]  status;
  } out_word_t;

endpackage

// File: rtl/buddy_allocator.sv
`timescale 1ns / 1ps

// buddy allocator over a word-addressed area, one header word per word in a
// single-port-read, single-port-write header memory
// input channel: in_valid_i / in_stall_o carry one request word (init,
// allocate, free); output channel: out_valid_o / out_stall_i carry one
// result word per request
// config channel: cfg_valid_i / cfg_ready_o, index 0 base address,
// index 1 area bytes; ready is always high, write only while idle
// one request at a time: in_stall_o is high from acceptance until the
// result is loaded into the output register
// init: writes one header per chunk, largest power-of-two chunks first, halving
// the chunk size wherever the next chunk would not fit in the area
// allocate: walks the chunk headers until a free chunk large enough is found,
// then splits it level by level, marks the chunk used and loads the result
// free: clears the used mark, then merges with equal-sized free buddies
// each loop step waits on the registered read of the header memory
// a result waiting under out_stall_i does not block the next request from
// being accepted; it only delays loading of the next result
// reset clears control state and the area size in use; header contents are
// undefined until the first init
module buddy_allocator #(
  parameter int AREA_WORDS = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ba_pkg::in_word_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ba_pkg::out_word_t out_word_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_index_i,
  input  logic [31:0]       cfg_data_i
);

  import ba_pkg::*;

  localparam int AW = $clog2(AREA_WORDS);
  localparam int HW = AW + 1;
  localparam int SW = AW + 2;
  localparam logic [SW-1:0] CAP = SW'(AREA_WORDS) & ~SW'(1);
  localparam logic [SW-1:0] TOP = SW'(1) << AW;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_INIT     = 8'b0000_0010,
    S_WALK     = 8'b0000_0100,
    S_SPLIT    = 8'b0000_1000,
    S_FREE_CLR = 8'b0001_0000,
    S_FREE_CMP = 8'b0010_0000,
    S_DONE     = 8'b0100_0000,
    S_SPARE    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic [31:0] base_q, base_d;
  logic [14:0] area_bytes_q, area_bytes_d;
  logic [SW-1:0] words_q, words_d;
  logic [SW-1:0] off_q, off_d;
  logic [SW-1:0] sz_q, sz_d;
  logic [SW-1:0] w_q, w_d;
  logic [31:0] res_addr_q, res_addr_d;
  logic [1:0] res_status_q, res_status_d;
  logic out_valid_q, out_valid_d;
  out_word_t out_word_q, out_word_d;

  logic mem_rd_en, mem_wr_en;
  logic [AW-1:0] mem_rd_addr, mem_wr_addr;
  logic [HW-1:0] mem_rd_data, mem_wr_data;

  logic in_acc;
  logic [32:0] bytes_p7;
  logic [30:0] req_words;
  logic [SW-1:0] req_fp;
  logic [31:0] raw_words;
  logic [31:0] diff;
  logic [29:0] free_off;
  logic [31:0] off_bytes;
  logic [SW-1:0] sum, step, hval, twin, noff, nsz, nbud;

  ba_hdr_mem #(
    .DEPTH(AREA_WORDS),
    .AW   (AW),
    .DW   (HW)
  ) u_mem (
    .clk_i    (clk_i),
    .rd_en_i  (mem_rd_en),
    .rd_addr_i(mem_rd_addr),
    .rd_data_o(mem_rd_data),
    .wr_en_i  (mem_wr_en),
    .wr_addr_i(mem_wr_addr),
    .wr_data_i(mem_wr_data)
  );

  assign in_acc      = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  always_comb begin
    bytes_p7  = {1'b0, in_word_i.request_bytes} + 33'd7;
    req_words = bytes_p7[32:2];
    req_fp    = '0;
    for (int i = 0; i < AW; i++) begin
      if (req_words[i]) begin
        req_fp = SW'(1) << i;
      end
    end
    raw_words = {19'd0, area_bytes_q[14:3], 1'b0};
    diff      = in_word_i.free_address - base_q;
    free_off  = diff[31:2] - 30'd1;
    hval      = SW'(mem_rd_data);
    off_bytes = 32'(off_q + SW'(1)) << 2;
  end

  always_comb begin
    state_d      = state_q;
    base_d       = base_q;
    area_bytes_d = area_bytes_q;
    words_d      = words_q;
    off_d        = off_q;
    sz_d         = sz_q;
    w_d          = w_q;
    res_addr_d   = res_addr_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q;
    out_word_d   = out_word_q;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = off_q[AW-1:0];
    mem_wr_en    = 1'b0;
    mem_wr_addr  = off_q[AW-1:0];
    mem_wr_data  = sz_q[HW-1:0];
    sum          = off_q + sz_q;
    step         = '0;
    twin         = off_q ^ sz_q;
    noff         = off_q;
    nsz          = sz_q;
    nbud         = off_q ^ sz_q;

    if (cfg_valid_i) begin
      if (cfg_index_i == CFG_BASE_ADDRESS) begin
        base_d = cfg_data_i;
      end else begin
        area_bytes_d = cfg_data_i[14:0];
      end
    end

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_addr_d   = '0;
          res_status_d = ST_DONE;
          case (in_word_i.operation)
            OP_INIT: begin
              if (raw_words > 32'(CAP)) begin
                words_d = CAP;
              end else begin
                words_d = SW'(raw_words);
              end
              off_d   = '0;
              sz_d    = TOP;
              state_d = S_INIT;
            end
            OP_ALLOC: begin
              if (in_word_i.request_bytes == '0 || (req_words >> AW) != '0) begin
                res_status_d = ST_FAIL;
                state_d      = S_DONE;
              end else begin
                w_d         = req_fp << 1;
                off_d       = '0;
                mem_rd_en   = 1'b1;
                mem_rd_addr = '0;
                state_d     = S_WALK;
              end
            end
            OP_FREE: begin
              if (in_word_i.free_address == '0 || diff[1:0] != 2'd0 || diff < 32'd4
                  || 32'(free_off) >= 32'(words_q)) begin
                res_status_d = ST_IGNORED;
                state_d      = S_DONE;
              end else begin
                off_d       = SW'(free_off);
                mem_rd_en   = 1'b1;
                mem_rd_addr = free_off[AW-1:0];
                state_d     = S_FREE_CLR;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_INIT: begin
        if (sum > words_q) begin
          sz_d = sz_q >> 1;
        end else begin
          mem_wr_en = 1'b1;
          if (sum >= words_q) begin
            state_d = S_DONE;
          end else begin
            off_d = sum;
          end
        end
      end
      S_WALK: begin
        if (!hval[0] && hval >= w_q) begin
          sz_d    = hval;
          state_d = S_SPLIT;
        end else begin
          step = hval & ~SW'(1);
          if (step < w_q) begin
            step = w_q;
          end
          if (off_q + step >= words_q) begin
            res_status_d = ST_FAIL;
            state_d      = S_DONE;
          end else begin
            off_d       = off_q + step;
            mem_rd_en   = 1'b1;
            mem_rd_addr = off_d[AW-1:0];
          end
        end
      end
      S_SPLIT: begin
        if (sz_q > w_q) begin
          nsz         = sz_q >> 1;
          sum         = off_q + nsz;
          sz_d        = nsz;
          mem_wr_en   = (sum < SW'(AREA_WORDS));
          mem_wr_addr = sum[AW-1:0];
          mem_wr_data = nsz[HW-1:0];
        end else begin
          mem_wr_en   = 1'b1;
          mem_wr_data = sz_q[HW-1:0] + HW'(1);
          res_addr_d  = base_q + off_bytes;
          state_d     = S_DONE;
        end
      end
      S_FREE_CLR: begin
        nsz         = hval & ~SW'(1);
        twin        = off_q ^ nsz;
        sz_d        = nsz;
        mem_wr_en   = 1'b1;
        mem_wr_data = nsz[HW-1:0];
        if (nsz == '0 || twin >= words_q) begin
          state_d = S_DONE;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = twin[AW-1:0];
          state_d     = S_FREE_CMP;
        end
      end
      S_FREE_CMP: begin
        if (hval != sz_q) begin
          state_d = S_DONE;
        end else begin
          noff        = (twin < off_q) ? twin : off_q;
          nsz         = sz_q << 1;
          nbud        = noff ^ nsz;
          mem_wr_en   = 1'b1;
          mem_wr_addr = noff[AW-1:0];
          mem_wr_data = nsz[HW-1:0];
          off_d       = noff;
          sz_d        = nsz;
          if (nbud >= words_q) begin
            state_d = S_DONE;
          end else begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = nbud[AW-1:0];
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d        = 1'b1;
          out_word_d.address = res_addr_q;
          out_word_d.status  = res_status_q;
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      base_q       <= '0;
      area_bytes_q <= AREA_BYTES_RESET;
      words_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      base_q       <= base_d;
      area_bytes_q <= area_bytes_d;
      words_q      <= words_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q        <= off_d;
    sz_q         <= sz_d;
    w_q          <= w_d;
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
    out_word_q   <= out_word_d;
  end

endmodule

// File: rtl/ba_hdr_mem.sv
`timescale 1ns / 1ps

module ba_hdr_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 13
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/ba_checker.sv
`timescale 1ns / 1ps

module ba_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input ba_pkg::out_word_t out_word_o
);

  import ba_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result word changed");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.status != ST_RESERVED)
    else $error("reserved status code");

  a_fail_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status != ST_DONE |-> out_word_o.address == '0)
    else $error("address on failed request");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request accepted while busy");

endmodule

bind buddy_allocator ba_checker u_ba_checker (.*);

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ba_pkg::*;

  localparam int HDR_DEPTH = 4096;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall_o;
  in_word_t    in_word = '0;
  logic        out_valid_o;
  logic        out_stall = 1'b0;
  out_word_t   out_word_o;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index = CFG_BASE_ADDRESS;
  logic [31:0] cfg_data = '0;

  buddy_allocator #(.AREA_WORDS(HDR_DEPTH)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // allocator shadow state
  int unsigned hdr [HDR_DEPTH];
  bit          hdr_set [HDR_DEPTH];
  int unsigned words_in_use;
  logic [31:0] shadow_base;
  logic [14:0] shadow_area;
  bit          stale_read;

  in_word_t    req_q [$];
  out_word_t   result_q [$];
  logic [31:0] live_q [$];

  bit          quiet = 1'b0;
  bit          tx_hold = 1'b0;
  logic        hold_start = 1'b0;
  int          hold_left = 0;
  int          tx_gap = 0;
  int          rx_gap = 0;
  int          errors = 0;
  int          n_sent = 0;
  int          n_got = 0;
  int          n_alloc_ok = 0;
  int          n_alloc_fail = 0;
  int          n_free_ok = 0;
  int          n_free_ign = 0;

  function automatic int unsigned hdr_rd(int unsigned idx);
    if (!hdr_set[idx]) stale_read = 1'b1;
    return hdr[idx];
  endfunction

  function automatic void hdr_wr(int unsigned idx, int unsigned val);
    hdr[idx] = val;
    hdr_set[idx] = 1'b1;
  endfunction

  function automatic void area_setup();
    int unsigned words, sz, off;
    words = (shadow_area >> 2) & ~32'd1;
    if (words > (HDR_DEPTH & ~1)) words = HDR_DEPTH & ~1;
    words_in_use = words;
    sz = words;
    off = 0;
    while (sz & (sz - 1)) sz &= sz - 1;
    forever begin
      hdr_wr(off, sz);
      if (off + sz >= words) return;
      off += sz;
      while (off + sz > words) sz >>= 1;
    end
  endfunction

  function automatic bit area_take(logic [31:0] bytes, output logic [31:0] addr);
    longint unsigned w, off, h, step;
    addr = '0;
    off = 0;
    if (bytes == 0) return 1'b0;
    w = (longint'(bytes) + 7) >> 2;
    while (w & (w - 1)) w &= w - 1;
    w <<= 1;
    forever begin
      h = hdr_rd(off);
      if (!h[0] && h >= w) break;
      step = h & ~64'd1;
      if (step < w) step = w;
      if (off + step >= words_in_use) return 1'b0;
      off += step;
    end
    while (longint'(hdr_rd(off)) > w) begin
      h = hdr_rd(off) >> 1;
      hdr_wr(off, h);
      if (off + h < HDR_DEPTH) hdr_wr(off + h, h);
    end
    hdr_wr(off, hdr_rd(off) + 1);
    addr = shadow_base + 32'(4 * (off + 1));
    return 1'b1;
  endfunction

  function automatic bit area_release(logic [31:0] addr);
    logic [31:0] diff;
    int unsigned off, h, twin;
    if (addr == 0) return 1'b0;
    diff = addr - shadow_base;
    if (diff[1:0] != 0 || diff < 4) return 1'b0;
    off = (diff >> 2) - 1;
    if (off >= words_in_use) return 1'b0;
    hdr_wr(off, hdr_rd(off) & ~32'd1);
    forever begin
      h = hdr_rd(off);
      if (h == 0) return 1'b1;
      twin = off ^ h;
      if (twin >= words_in_use) return 1'b1;
      if (hdr_rd(twin) != h) return 1'b1;
      if (twin < off) off = twin;
      hdr_wr(off, h << 1);
    end
  endfunction

  // queue a request with its predicted result; skipped if it would touch
  // header entries never written
  function automatic void queue_req(op_e op, logic [31:0] req, logic [31:0] fa);
    int unsigned hdr_sv [HDR_DEPTH];
    bit          set_sv [HDR_DEPTH];
    int unsigned words_sv;
    in_word_t    w;
    out_word_t   r;
    bit          ok;
    hdr_sv = hdr;
    set_sv = hdr_set;
    words_sv = words_in_use;
    stale_read = 1'b0;
    r = '0;
    r.status = ST_DONE;
    ok = 1'b0;
    case (op)
      OP_INIT: area_setup();
      OP_ALLOC: begin
        ok = area_take(req, r.address);
        if (!ok) r.status = ST_FAIL;
      end
      OP_FREE: begin
        ok = area_release(fa);
        if (!ok) r.status = ST_IGNORED;
      end
      default: ;
    endcase
    if (stale_read) begin
      hdr = hdr_sv;
      hdr_set = set_sv;
      words_in_use = words_sv;
      return;
    end
    if (op == OP_INIT) live_q.delete();
    if (op == OP_ALLOC) begin
      if (ok) begin
        live_q.push_back(r.address);
        n_alloc_ok++;
      end else begin
        n_alloc_fail++;
      end
    end
    if (op == OP_FREE) begin
      if (ok) n_free_ok++;
      else n_free_ign++;
    end
    w.operation = op;
    w.request_bytes = req;
    w.free_address = fa;
    req_q.push_back(w);
    result_q.push_back(r);
  endfunction

  function automatic logic [31:0] rand_size();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 0;
      2, 3: return $urandom_range(1, 2000);
      default: return $urandom_range(1, 60);
    endcase
  endfunction

  function automatic void queue_random();
    int k;
    logic [31:0] a;
    k = $urandom_range(0, 99);
    if (k < 50) begin
      queue_req(OP_ALLOC, rand_size(), $urandom());
    end else if (k < 88 && live_q.size() > 0) begin
      k = $urandom_range(0, live_q.size() - 1);
      a = live_q[k];
      live_q.delete(k);
      queue_req(OP_FREE, $urandom(), a);
    end else if (k < 92) begin
      a = shadow_base + 4 * $urandom_range(1, words_in_use + 2);
      queue_req(OP_FREE, $urandom(), a);
    end else if (k < 95) begin
      queue_req(OP_FREE, $urandom(), $urandom());
    end else if (k < 97) begin
      queue_req(OP_NONE, $urandom(), $urandom());
    end else if (k < 98) begin
      queue_req(OP_FREE, $urandom(), '0);
    end else begin
      queue_req(OP_INIT, $urandom(), $urandom());
    end
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) n_sent <= n_sent + 1;
      if (!in_valid || !in_stall_o) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (req_q.size() > 0 && !tx_hold) begin
          in_word <= req_q.pop_front();
          in_valid <= 1'b1;
          if (!quiet && $urandom_range(0, 11) == 0) tx_gap <= $urandom_range(1, 15);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_start) hold_left <= 400;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t exp_w;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        n_got <= n_got + 1;
        if (result_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result word %h", out_word_o);
        end else begin
          exp_w = result_q.pop_front();
          if (out_word_o.address !== exp_w.address || out_word_o.status !== exp_w.status) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected addr %h status %0d, got addr %h status %0d",
                       exp_w.address, exp_w.status, out_word_o.address, out_word_o.status);
          end
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        rx_gap <= $urandom_range(0, 14);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic wait_idle();
    while (req_q.size() != 0 || in_valid || result_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    if (idx == CFG_BASE_ADDRESS) shadow_base = data;
    else shadow_area = data[14:0];
  endtask

  initial begin
    logic [31:0] bases [6];
    logic [14:0] areas [6];
    shadow_base = '0;
    shadow_area = AREA_BYTES_RESET;
    words_in_use = 0;
    foreach (hdr_set[i]) hdr_set[i] = 1'b0;
    bases = '{32'h0, 32'hFFFF_FFFC, 32'h1000_0000, 32'h0, 32'h8000_0004, 32'h0000_4000};
    areas = '{15'd16384, 15'd8, 15'd100, 15'd32767, 15'd1024, 15'd16384};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    for (int ph = 0; ph < 6; ph++) begin
      cfg_write(CFG_BASE_ADDRESS, bases[ph]);
      cfg_write(CFG_AREA_BYTES, {17'h0, areas[ph]});
      if (ph == 5) quiet = 1'b1;
      queue_req(OP_INIT, '0, '0);
      if (ph == 0) begin
        queue_req(OP_ALLOC, 32'd0, '0);
        queue_req(OP_ALLOC, 32'd1, '0);
        queue_req(OP_ALLOC, 32'd4, '0);
        queue_req(OP_ALLOC, 32'd5, '0);
        queue_req(OP_ALLOC, 32'd100, '0);
        queue_req(OP_ALLOC, 32'hFFFF_FFFF, '0);
        queue_req(OP_ALLOC, 32'h8000_0000, '0);
        queue_req(OP_ALLOC, 32'd8192, '0);
        queue_req(OP_FREE, '0, 32'd0);
        queue_req(OP_FREE, '0, shadow_base + 2);
        queue_req(OP_FREE, '0, shadow_base);
        queue_req(OP_FREE, '0, shadow_base + 4 * (words_in_use + 1));
        queue_req(OP_FREE, '0, shadow_base + 12);
        queue_req(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        while (live_q.size() > 0) queue_req(OP_FREE, '0, live_q.pop_front());
        queue_req(OP_ALLOC, 32'd16380, '0);
        queue_req(OP_ALLOC, 32'd1, '0);
      end
      if (ph == 1) begin
        @(posedge clk_i);
        hold_start <= 1'b1;
        @(posedge clk_i);
        hold_start <= 1'b0;
      end
      for (int i = 0; i < 330; i++) queue_random();
      if (ph == 2) begin
        wait_idle();
        tx_hold = 1'b1;
        repeat (30) @(posedge clk_i);
        tx_hold = 1'b0;
        for (int i = 0; i < 40; i++) queue_random();
      end
      wait_idle();
    end

    repeat (50) @(posedge clk_i);
    $display("ran %0d requests over 6 base/area settings, %0d results checked",
             n_sent, n_got);
    $display("allocs ok %0d, failed %0d; frees done %0d, ignored %0d; errors %0d",
             n_alloc_ok, n_alloc_fail, n_free_ok, n_free_ign, errors);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("timeout");
    $display("Test completed with failures");
    $finish;
  end

endmodule
